>>> rtl/core/base64_stream_decoder_top_assert.svh
// Assertion macros shared by the checker of the base64 stream decoder.
// Depends on nothing; included by the checker file only.
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64sd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64sd check failed");

`endif

>>> rtl/core/b64sd_pkg.sv
// Shared types, codes and the sextet lookup of the base64 stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package b64sd_pkg;

    localparam logic [15:0] PAD_UNIT = 16'h003D;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;

    localparam logic [1:0] POS_LAST = 2'd3;

    // One queued transaction bundle: up to three bytes plus an optional close.
    typedef struct packed {
        logic [1:0]  status;
        logic        close;
        logic [2:0]  byte_en;   // bit 0 = first byte
        logic [23:0] bytes;     // first byte in [7:0]
    } job_t;

    // Bit 6 set marks a character outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] res;
        res = 7'd64;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            res = 7'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            res = 7'(ch - 8'h61 + 8'd26);
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res = 7'(ch - 8'h30 + 8'd52);
        end
        else if (ch == 8'h2B || ch == 8'h2D)
        begin
            res = 7'd62;
        end
        else if (ch == 8'h2F || ch == 8'h5F)
        begin
            res = 7'd63;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/b64sd_queue.sv
// Small job queue between the front and back parts of the decoder.
// Depends on b64sd_pkg (job_t).
`timescale 1ns / 1ps

module b64sd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64sd_pkg::job_t push_data,
    input  logic            pop,
    output b64sd_pkg::job_t pop_data,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64sd_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/b64sd_front.sv
// Front part: accepts code units, maps them to sextets, tracks group state
// and builds one job per unit that causes results. Depends on b64sd_pkg.
`timescale 1ns / 1ps

module b64sd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [15:0]     code_unit,
    input  logic            end_of_text,
    input  logic            queue_full,
    output logic            push,
    output b64sd_pkg::job_t job
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] held_reg, held_next;
    logic        third_pad_reg, third_pad_next;
    logic        group_bad_reg, group_bad_next;
    logic        error_reg, error_next;

    logic        accept;
    logic        is_pad;
    logic        pad_ok;
    logic [6:0]  lookup;
    logic        bad_now;
    logic [5:0]  sx;
    logic        gb_all;
    logic        err_all;
    logic [5:0]  sa, sb, sc;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign is_pad  = (code_unit == b64sd_pkg::PAD_UNIT);
    assign pad_ok  = pos_reg[1] && is_pad;
    assign lookup  = b64sd_pkg::sextet_of(code_unit[7:0]);
    assign bad_now = !pad_ok && lookup[6];
    assign sx      = (pad_ok || lookup[6]) ? 6'd0 : lookup[5:0];
    assign gb_all  = group_bad_reg || bad_now;
    assign err_all = error_reg || gb_all;

    assign sa = held_reg[17:12];
    assign sb = held_reg[11:6];
    assign sc = held_reg[5:0];

    always_comb
    begin
        pos_next       = pos_reg;
        held_next      = held_reg;
        third_pad_next = third_pad_reg;
        group_bad_next = group_bad_reg;
        error_next     = error_reg;
        job            = '0;
        job.bytes      = {sc[1:0], sx, sb[3:0], sc[5:2], sa, sb[5:4]};

        if (pos_reg != b64sd_pkg::POS_LAST)
        begin
            held_next      = {held_reg[11:0], sx};
            group_bad_next = gb_all;
            pos_next       = pos_reg + 2'd1;
            if (pos_reg == 2'd2)
            begin
                third_pad_next = is_pad;
            end
        end
        else
        begin
            error_next     = err_all;
            job.byte_en    = err_all ? 3'b000 : {!is_pad, !third_pad_reg, 1'b1};
            pos_next       = '0;
            held_next      = '0;
            third_pad_next = 1'b0;
            group_bad_next = 1'b0;
        end

        if (end_of_text)
        begin
            job.close = 1'b1;
            if (pos_reg != b64sd_pkg::POS_LAST)
            begin
                job.status = b64sd_pkg::STATUS_BAD_LEN;
            end
            else if (err_all)
            begin
                job.status = b64sd_pkg::STATUS_BAD_CHAR;
            end
            else
            begin
                job.status = b64sd_pkg::STATUS_OK;
            end
            pos_next       = '0;
            held_next      = '0;
            third_pad_next = 1'b0;
            group_bad_next = 1'b0;
            error_next     = 1'b0;
        end
    end

    assign push = accept && (job.close || (job.byte_en != 3'b000));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            held_reg      <= '0;
            third_pad_reg <= 1'b0;
            group_bad_reg <= 1'b0;
            error_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            third_pad_reg <= third_pad_next;
            group_bad_reg <= group_bad_next;
            error_reg     <= error_next;
        end
    end

endmodule

>>> rtl/core/b64sd_back.sv
// Back part: takes queued jobs and sends their bytes, then the closing
// status, one per cycle while out_ready is high. Depends on b64sd_pkg.
`timescale 1ns / 1ps

module b64sd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            queue_empty,
    input  b64sd_pkg::job_t queue_data,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      data_byte,
    output logic            byte_valid,
    output logic [1:0]      status,
    output logic            final_item
);

    b64sd_pkg::job_t cur_reg, cur_next, cur_upd;
    logic            cur_valid_reg, cur_valid_next;

    logic            out_valid_reg, out_valid_next;
    logic [7:0]      data_reg, data_next;
    logic            bvalid_reg, bvalid_next;
    logic [1:0]      status_reg, status_next;
    logic            last_reg, last_next;

    logic            advance;
    logic            done;

    assign advance = cur_valid_reg && (!out_valid_reg || out_ready);

    // Pick the next pending result of the current job.
    always_comb
    begin
        cur_upd     = cur_reg;
        data_next   = data_reg;
        bvalid_next = bvalid_reg;
        status_next = status_reg;
        last_next   = last_reg;
        priority if (cur_reg.byte_en[0])
        begin
            data_next          = cur_reg.bytes[7:0];
            bvalid_next        = 1'b1;
            status_next        = b64sd_pkg::STATUS_OK;
            last_next          = 1'b0;
            cur_upd.byte_en[0] = 1'b0;
        end
        else if (cur_reg.byte_en[1])
        begin
            data_next          = cur_reg.bytes[15:8];
            bvalid_next        = 1'b1;
            status_next        = b64sd_pkg::STATUS_OK;
            last_next          = 1'b0;
            cur_upd.byte_en[1] = 1'b0;
        end
        else if (cur_reg.byte_en[2])
        begin
            data_next          = cur_reg.bytes[23:16];
            bvalid_next        = 1'b1;
            status_next        = b64sd_pkg::STATUS_OK;
            last_next          = 1'b0;
            cur_upd.byte_en[2] = 1'b0;
        end
        else
        begin
            data_next     = 8'd0;
            bvalid_next   = 1'b0;
            status_next   = cur_reg.status;
            last_next     = 1'b1;
            cur_upd.close = 1'b0;
        end
    end

    assign done = (cur_upd.byte_en == 3'b000) && !cur_upd.close;
    assign pop  = !queue_empty && (!cur_valid_reg || (advance && done));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_next       = queue_data;
            cur_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cur_next       = cur_upd;
            cur_valid_next = !done;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            data_reg   <= data_next;
            bvalid_reg <= bvalid_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_reg;
    assign byte_valid = bvalid_reg;
    assign status     = status_reg;
    assign final_item = last_reg;

endmodule

>>> rtl/core/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder: front, job queue and back.
// Depends on b64sd_pkg, b64sd_front, b64sd_queue, b64sd_back.
//
//  channel   | dir | tdata                         | tuser       | tlast
//  ----------+-----+-------------------------------+-------------+------------
//  s_axis    | in  | [15:0] code_unit              | -           | end_of_text
//  m_axis    | out | [7:0] data_byte, [9:8] status | byte_valid  | final_item
//
// Flow: one code unit is accepted per cycle while the job queue has room;
// results leave one per cycle while m_axis_tready is high, so a group of
// four units gives up to four results (three bytes, plus the status on the
// last unit). The output register is the rate-setting port. The first
// result of a unit passes the queue write on the accepting edge, then the
// job register, then the output register.
// Reset: rst_n clears group state, queue pointers and valid flags at once.
// Stalls: m_axis_tready low backs up into the queue; s_axis_tready drops only
// when the queue is full.
`timescale 1ns / 1ps

module base64_stream_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // end_of_text
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status, rest zero
    output logic        m_axis_tuser,   // [0] byte_valid
    output logic        m_axis_tlast    // final_item
);

    b64sd_pkg::job_t push_job;
    b64sd_pkg::job_t pop_job;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    logic [7:0]      data_byte;
    logic [1:0]      status;

    // Front: classifies each unit and builds the transaction bundle it causes.
    b64sd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .code_unit   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .queue_full  (q_full),
        .push        (push),
        .job         (push_job)
    );

    // Queue decouples the one-per-cycle input from the serialised output.
    b64sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: serialises bytes and the closing status into the output register.
    b64sd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .queue_data  (pop_job),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .data_byte   (data_byte),
        .byte_valid  (m_axis_tuser),
        .status      (status),
        .final_item  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, status, data_byte};

endmodule

>>> rtl/core/b64sd_checker.sv
// Port-level checker for the base64 stream decoder, bound to the top level.
// Depends on base64_stream_decoder_top_assert.svh.
`timescale 1ns / 1ps
`include "base64_stream_decoder_top_assert.svh"

module b64sd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A byte transaction never closes a string and carries status zero.
    `B64SD_ASSERT_NOW(a_byte_form, clk, rst_n, m_axis_tvalid && m_axis_tuser, !m_axis_tlast && (m_axis_tdata[9:8] == 2'd0))

    // The status transaction closes the string, has no data and a legal code.
    `B64SD_ASSERT_NOW(a_status_form, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[9:8] != 2'd3))

    // Padding bits above the status stay clear.
    `B64SD_ASSERT_NOW(a_tdata_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[15:10] == 6'd0)

    // A stalled result holds.
    `B64SD_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind base64_stream_decoder_top b64sd_checker u_b64sd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb_base64_stream_decoder_top.sv
// Self-checking testbench for the base64 stream decoder top level.
// Depends on b64sd_pkg and base64_stream_decoder_top; predicts bytes and closing status.
`timescale 1ns / 1ps

module tb_base64_stream_decoder_top;

    localparam int WATCHDOG_LIMIT = 1000;   // quiet cycles before giving up
    localparam int RANDOM_UNITS   = 360;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 16;

    // One output transaction as the decoder should produce it
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       final_item;
    } b64_result_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'h0000;   // [15:0] code_unit
    logic        s_axis_tlast  = 1'b0;       // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;                // [7:0] data_byte, [9:8] status
    logic        m_axis_tuser;                // [0] byte_valid
    logic        m_axis_tlast;                // final_item

    // decoder state mirror
    logic [1:0]  grp_pos;
    logic [17:0] held_sx;
    logic        third_pad;
    logic        grp_bad;
    logic        err_seen;

    b64_result_t decoded_fifo[$];
    logic [15:0] text_q[$];
    int          mismatches = 0;
    int          units_sent = 0;
    bit          no_idle    = 1'b0;

    base64_stream_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Bit 6 flags a character outside the alphabet.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
        logic [6:0] sx;
        sx = 7'h40;
        if (ch >= "A" && ch <= "Z")
        begin
            sx = {1'b0, 6'(ch - 8'h41)};
        end
        else if (ch >= "a" && ch <= "z")
        begin
            sx = {1'b0, 6'(ch - 8'h61 + 8'd26)};
        end
        else if (ch >= "0" && ch <= "9")
        begin
            sx = {1'b0, 6'(ch - 8'h30 + 8'd52)};
        end
        else if (ch == "+" || ch == "-")
        begin
            sx = 7'd62;
        end
        else if (ch == "/" || ch == "_")
        begin
            sx = 7'd63;
        end
        return sx;
    endfunction

    function automatic void clear_decoder_state();
        grp_pos   = 2'd0;
        held_sx   = 18'd0;
        third_pad = 1'b0;
        grp_bad   = 1'b0;
        err_seen  = 1'b0;
    endfunction

    function automatic void push_decoded_byte(input logic [7:0] b);
        b64_result_t r;
        r.data_byte  = b;
        r.byte_valid = 1'b1;
        r.status     = b64sd_pkg::STATUS_OK;
        r.final_item = 1'b0;
        decoded_fifo.insert(decoded_fifo.size(), r);
    endfunction

    // Works out the results caused by one accepted code unit.
    function automatic void decode_unit(input logic [15:0] unit, input logic last);
        logic        is_pad;
        logic [6:0]  sx;
        logic [1:0]  pos;
        logic [5:0]  a;
        logic [5:0]  b;
        logic [5:0]  c;
        b64_result_t close_r;
        is_pad = (unit == b64sd_pkg::PAD_UNIT);
        sx     = char_to_sextet(unit[7:0]);
        pos    = grp_pos;
        // a pad counts as zero only in the back half of a group
        if (pos >= 2'd2 && is_pad)
        begin
            sx = 7'd0;
        end
        else if (sx[6])
        begin
            grp_bad = 1'b1;
            sx      = 7'd0;
        end
        if (pos != b64sd_pkg::POS_LAST)
        begin
            held_sx = {held_sx[11:0], sx[5:0]};
            if (pos == 2'd2)
            begin
                third_pad = is_pad;
            end
            grp_pos = pos + 2'd1;
        end
        else
        begin
            a = held_sx[17:12];
            b = held_sx[11:6];
            c = held_sx[5:0];
            if (grp_bad)
            begin
                err_seen = 1'b1;
            end
            // once an error is seen nothing more of the string comes out
            if (!err_seen)
            begin
                push_decoded_byte({a, b[5:4]});
                if (!third_pad)
                begin
                    push_decoded_byte({b[3:0], c[5:2]});
                end
                if (!is_pad)
                begin
                    push_decoded_byte({c[1:0], sx[5:0]});
                end
            end
            grp_pos   = 2'd0;
            held_sx   = 18'd0;
            third_pad = 1'b0;
            grp_bad   = 1'b0;
        end
        if (last)
        begin
            close_r.data_byte  = 8'h00;
            close_r.byte_valid = 1'b0;
            close_r.final_item = 1'b1;
            // short length wins over a bad character
            if (pos != b64sd_pkg::POS_LAST)
            begin
                close_r.status = b64sd_pkg::STATUS_BAD_LEN;
            end
            else if (err_seen)
            begin
                close_r.status = b64sd_pkg::STATUS_BAD_CHAR;
            end
            else
            begin
                close_r.status = b64sd_pkg::STATUS_OK;
            end
            decoded_fifo.insert(decoded_fifo.size(), close_r);
            clear_decoder_state();
        end
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Presents one code unit after a random gap and waits for its transaction.
    // Valid stays high straight into the next unit when the gap is zero.
    task automatic send_unit(input logic [15:0] unit, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= unit;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        decode_unit(unit, last);
        units_sent++;
    endtask

    // Sends the buffered text, flagging the final unit.
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
        begin
            send_unit(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    task automatic add_unit(input logic [15:0] unit);
        text_q.insert(text_q.size(), unit);
    endtask

    task automatic append_ascii(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_unit({8'h00, s[i]});
        end
    endtask

    // Random member of the alphabet, now and then with a non-zero high byte.
    function automatic logic [15:0] random_text_char();
        int         idx;
        logic [7:0] ch;
        logic [7:0] hi;
        idx = $urandom_range(0, 65);
        if (idx < 26)
        begin
            ch = 8'h41 + 8'(idx);
        end
        else if (idx < 52)
        begin
            ch = 8'h61 + 8'(idx - 26);
        end
        else if (idx < 62)
        begin
            ch = 8'h30 + 8'(idx - 52);
        end
        else if (idx == 62)
        begin
            ch = "+";
        end
        else if (idx == 63)
        begin
            ch = "/";
        end
        else if (idx == 64)
        begin
            ch = "-";
        end
        else
        begin
            ch = "_";
        end
        hi = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        return {hi, ch};
    endfunction

    // ---------------------------------------------------------------
    // Output side: random back-pressure, one draw per transaction
    // ---------------------------------------------------------------
    initial
    begin : sink_pacing
        int stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    // Every output transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        b64_result_t got;
        b64_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data_byte  = m_axis_tdata[7:0];
            got.status     = m_axis_tdata[9:8];
            got.byte_valid = m_axis_tuser;
            got.final_item = m_axis_tlast;
            if (decoded_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result byte=%h valid=%b status=%0d last=%b",
                             $realtime, got.data_byte, got.byte_valid, got.status,
                             got.final_item);
                end
            end
            else
            begin
                want = decoded_fifo.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch exp byte=%h valid=%b status=%0d last=%b",
                                 $realtime, want.data_byte, want.byte_valid, want.status,
                                 want.final_item);
                        $display("%0t:          got byte=%h valid=%b status=%0d last=%b",
                                 $realtime, got.data_byte, got.byte_valid, got.status,
                                 got.final_item);
                    end
                end
            end
        end
    end

    // Ends the run when neither side has moved a transaction for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // A, z, both ends of the digits, and both spellings of 62 and 63.
    task automatic test_alphabet_extremes();
        append_ascii("Az09-_+/");
        send_text();
    endtask

    // Double pad, then a pad in the third slot only in the next group.
    task automatic test_padding();
        append_ascii("TQ==TW=u");
        send_text();
    endtask

    // Pad in a leading slot, a high byte on a good character, a pad with a
    // non-zero high byte and an all-ones unit; the later group must stay silent.
    task automatic test_invalid_units();
        add_unit(b64sd_pkg::PAD_UNIT);
        add_unit(16'hFF41);
        add_unit(16'h013D);
        add_unit(16'hFFFF);
        append_ascii("AAAA");
        send_text();
        add_unit(16'h4100);
        add_unit(b64sd_pkg::PAD_UNIT);
        append_ascii("AA");
        send_text();
    endtask

    // Short strings: a lone pad, then two characters.
    task automatic test_bad_length();
        add_unit(b64sd_pkg::PAD_UNIT);
        send_text();
        append_ascii("QU");
        send_text();
    endtask

    // Mostly well-formed strings with random content, plus corrupted strings,
    // strings of wrong length and raw noise.
    task automatic test_random_text();
        int kind;
        int groups;
        int len;
        int tail;
        int spot;
        while (units_sent < RANDOM_UNITS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 99);
            if (kind < 82)
            begin
                groups = $urandom_range(1, 3);
                for (int g = 0; g < groups; g++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        add_unit(random_text_char());
                    end
                    // pads on the final group mostly, sometimes mid-string
                    tail = (g == groups - 1 || $urandom_range(0, 5) == 0)
                           ? $urandom_range(0, 3) : 0;
                    case (tail)
                        1: text_q[text_q.size() - 1] = b64sd_pkg::PAD_UNIT;
                        2:
                        begin
                            text_q[text_q.size() - 2] = b64sd_pkg::PAD_UNIT;
                            text_q[text_q.size() - 1] = b64sd_pkg::PAD_UNIT;
                        end
                        3: text_q[text_q.size() - 2] = b64sd_pkg::PAD_UNIT;
                        default: ;
                    endcase
                end
                // corrupt one unit in some of them
                if (kind >= 70)
                begin
                    spot = $urandom_range(0, text_q.size() - 1);
                    if (spot % 4 < 2 && $urandom_range(0, 1) == 0)
                    begin
                        text_q[spot] = b64sd_pkg::PAD_UNIT;
                    end
                    else
                    begin
                        text_q[spot] = 16'($urandom_range(0, 65535));
                    end
                end
            end
            else if (kind < 92)
            begin
                len = $urandom_range(1, 11);
                if (len % 4 == 0)
                begin
                    len++;
                end
                for (int k = 0; k < len; k++)
                begin
                    add_unit(($urandom_range(0, 5) == 0) ? b64sd_pkg::PAD_UNIT
                                                         : random_text_char());
                end
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                begin
                    add_unit(16'($urandom_range(0, 65535)));
                end
            end
            send_text();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        clear_decoder_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alphabet_extremes();
        test_padding();
        test_invalid_units();
        test_bad_length();
        test_random_text();

        s_axis_tvalid <= 1'b0;
        while (decoded_fifo.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
